[src/voxel_face_visibility_defines.svh]
// Assertion macros shared by the checker of the voxel face visibility block.
`ifndef VOXEL_FACE_VISIBILITY_DEFINES_SVH
`define VOXEL_FACE_VISIBILITY_DEFINES_SVH

// Checked on every rising clock edge, quiet while reset is asserted.
`define VFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define VFV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/vfv_pkg.sv]
// Types, constants and helper functions of the voxel face visibility block.
package vfv_pkg;

  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 16;
  localparam int SIZE_Z = 16;

  localparam int COORD_W   = 4;
  localparam int LDEPTH    = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int LADDR_W   = $clog2(LDEPTH);
  localparam int PX_DEPTH  = SIZE_Y * SIZE_Z;
  localparam int PX_ADDR_W = $clog2(PX_DEPTH);
  localparam int PZ_DEPTH  = SIZE_X * SIZE_Y;
  localparam int PZ_ADDR_W = $clog2(PZ_DEPTH);
  localparam int CELL_W    = 2;
  localparam int NB_W      = 4;
  localparam int MASK_W    = 6;
  localparam int NUM_RD    = 7;

  typedef enum logic [1:0] {
    KIND_WR_LOCAL = 2'd0,
    KIND_WR_PLANE = 2'd1,
    KIND_QUERY    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SIDE_X_NEG = 2'd0,
    SIDE_X_POS = 2'd1,
    SIDE_Z_NEG = 2'd2,
    SIDE_Z_POS = 2'd3
  } side_e;

  localparam int RD_SELF = 0;
  localparam int RD_ZP   = 1;
  localparam int RD_XP   = 2;
  localparam int RD_ZN   = 3;
  localparam int RD_XN   = 4;
  localparam int RD_YP   = 5;
  localparam int RD_YN   = 6;

  localparam int FACE_ZP = 0;
  localparam int FACE_XP = 1;
  localparam int FACE_ZN = 2;
  localparam int FACE_XN = 3;
  localparam int FACE_YP = 4;
  localparam int FACE_YN = 5;

  localparam int NB_XN = 0;
  localparam int NB_XP = 1;
  localparam int NB_ZN = 2;
  localparam int NB_ZP = 3;

  typedef struct packed {
    logic transparent;
    logic occupied;
  } cell_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [1:0]         side;
    cell_t              bits;
    logic               water;
  } item_t;

  typedef struct packed {
    logic in_range;
    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;
    logic z_lo;
    logic z_hi;
    logic water;
  } info_t;

  typedef struct packed {
    cell_t [NUM_RD-1:0] cells;
    cell_t              px_neg;
    cell_t              px_pos;
    cell_t              pz_neg;
    cell_t              pz_pos;
  } rd_data_t;

  typedef struct packed {
    logic [MASK_W-1:0] face_mask;
    logic              self_occupied;
    logic              self_transparent;
  } res_t;

  function automatic logic [LADDR_W-1:0] local_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
    return LADDR_W'((32'(x) * SIZE_Y + 32'(y)) * SIZE_Z + 32'(z));
  endfunction

  function automatic logic [PX_ADDR_W-1:0] px_addr(input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
    return PX_ADDR_W'(32'(y) * SIZE_Z + 32'(z));
  endfunction

  function automatic logic [PZ_ADDR_W-1:0] pz_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    return PZ_ADDR_W'(32'(x) * SIZE_Y + 32'(y));
  endfunction

  function automatic logic in_range(input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y,
                                    input logic [COORD_W-1:0] z);
    return (32'(x) < SIZE_X) && (32'(y) < SIZE_Y) && (32'(z) < SIZE_Z);
  endfunction

  // A neighbor lets a face show when it is empty, or transparent under the solid rule.
  function automatic logic open_face(input cell_t c, input logic water);
    return !c.occupied || (!water && c.transparent);
  endfunction

endpackage

[src/vfv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vfv_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/vfv_store.sv]
// Cell store: replicated local-cell memories, boundary planes and the clearing sweep.
module vfv_store import vfv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  item_t    item_i,
  output logic     busy_o,
  output info_t    info_o,
  output rd_data_t rd_o
);

  logic                 clr_busy_q, clr_busy_d;
  logic [LADDR_W-1:0]   clr_cnt_q, clr_cnt_d;

  logic                 lwe;
  logic [LADDR_W-1:0]   lwaddr;
  cell_t                wcell;
  logic [3:0]           pwe;
  logic [PX_ADDR_W-1:0] px_waddr;
  logic [PZ_ADDR_W-1:0] pz_waddr;

  logic                 re;
  logic [LADDR_W-1:0]   raddr [NUM_RD];
  logic [PX_ADDR_W-1:0] px_raddr;
  logic [PZ_ADDR_W-1:0] pz_raddr;
  logic [CELL_W-1:0]    rcell [NUM_RD];
  logic [CELL_W-1:0]    rplane [4];

  info_t                info_d, info_q;
  logic [LADDR_W-1:0]   self_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == LADDR_W'(LDEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  // Write side: the clearing sweep has priority; no transaction is taken meanwhile.
  always_comb begin
    lwe      = 1'b0;
    pwe      = '0;
    lwaddr   = local_addr(item_i.x, item_i.y, item_i.z);
    px_waddr = px_addr(item_i.y, item_i.z);
    pz_waddr = pz_addr(item_i.x, item_i.y);
    wcell    = item_i.bits;
    if (clr_busy_q) begin
      lwe      = 1'b1;
      lwaddr   = clr_cnt_q;
      wcell    = '0;
      px_waddr = clr_cnt_q[PX_ADDR_W-1:0];
      pz_waddr = clr_cnt_q[PZ_ADDR_W-1:0];
      pwe[SIDE_X_NEG] = clr_cnt_q < LADDR_W'(PX_DEPTH);
      pwe[SIDE_X_POS] = clr_cnt_q < LADDR_W'(PX_DEPTH);
      pwe[SIDE_Z_NEG] = clr_cnt_q < LADDR_W'(PZ_DEPTH);
      pwe[SIDE_Z_POS] = clr_cnt_q < LADDR_W'(PZ_DEPTH);
    end else if (fire_i) begin
      case (item_i.kind)
        KIND_WR_LOCAL: begin
          lwe = in_range(item_i.x, item_i.y, item_i.z);
        end
        KIND_WR_PLANE: begin
          case (item_i.side)
            SIDE_X_NEG: pwe[SIDE_X_NEG] = in_range('0, item_i.y, item_i.z);
            SIDE_X_POS: pwe[SIDE_X_POS] = in_range('0, item_i.y, item_i.z);
            SIDE_Z_NEG: pwe[SIDE_Z_NEG] = in_range(item_i.x, item_i.y, '0);
            SIDE_Z_POS: pwe[SIDE_Z_POS] = in_range(item_i.x, item_i.y, '0);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Read side: one address per memory copy; an edge neighbor reads the cell itself.
  always_comb begin
    re                = fire_i && (item_i.kind == KIND_QUERY);
    info_d.in_range   = in_range(item_i.x, item_i.y, item_i.z);
    info_d.x_lo       = item_i.x == '0;
    info_d.x_hi       = item_i.x == COORD_W'(SIZE_X - 1);
    info_d.y_lo       = item_i.y == '0;
    info_d.y_hi       = item_i.y == COORD_W'(SIZE_Y - 1);
    info_d.z_lo       = item_i.z == '0;
    info_d.z_hi       = item_i.z == COORD_W'(SIZE_Z - 1);
    info_d.water      = item_i.water;
    self_addr         = info_d.in_range ? local_addr(item_i.x, item_i.y, item_i.z) : '0;
    raddr[RD_SELF]    = self_addr;
    raddr[RD_ZP]      = self_addr;
    raddr[RD_XP]      = self_addr;
    raddr[RD_ZN]      = self_addr;
    raddr[RD_XN]      = self_addr;
    raddr[RD_YP]      = self_addr;
    raddr[RD_YN]      = self_addr;
    px_raddr          = '0;
    pz_raddr          = '0;
    if (info_d.in_range) begin
      px_raddr = px_addr(item_i.y, item_i.z);
      pz_raddr = pz_addr(item_i.x, item_i.y);
      if (!info_d.z_hi) begin
        raddr[RD_ZP] = local_addr(item_i.x, item_i.y, COORD_W'(item_i.z + 1'b1));
      end
      if (!info_d.z_lo) begin
        raddr[RD_ZN] = local_addr(item_i.x, item_i.y, COORD_W'(item_i.z - 1'b1));
      end
      if (!info_d.x_hi) begin
        raddr[RD_XP] = local_addr(COORD_W'(item_i.x + 1'b1), item_i.y, item_i.z);
      end
      if (!info_d.x_lo) begin
        raddr[RD_XN] = local_addr(COORD_W'(item_i.x - 1'b1), item_i.y, item_i.z);
      end
      if (!info_d.y_hi) begin
        raddr[RD_YP] = local_addr(item_i.x, COORD_W'(item_i.y + 1'b1), item_i.z);
      end
      if (!info_d.y_lo) begin
        raddr[RD_YN] = local_addr(item_i.x, COORD_W'(item_i.y - 1'b1), item_i.z);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      info_q <= info_d;
    end
  end

  for (genvar i = 0; i < NUM_RD; i++) begin : g_local
    vfv_ram #(
      .DEPTH(LDEPTH),
      .WIDTH(CELL_W)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (lwe),
      .waddr_i (lwaddr),
      .wdata_i (wcell),
      .re_i    (re),
      .raddr_i (raddr[i]),
      .rdata_o (rcell[i])
    );
  end

  vfv_ram #(.DEPTH(PX_DEPTH), .WIDTH(CELL_W)) u_px_neg (
    .clk_i   (clk_i),
    .we_i    (pwe[SIDE_X_NEG]),
    .waddr_i (px_waddr),
    .wdata_i (wcell),
    .re_i    (re),
    .raddr_i (px_raddr),
    .rdata_o (rplane[SIDE_X_NEG])
  );

  vfv_ram #(.DEPTH(PX_DEPTH), .WIDTH(CELL_W)) u_px_pos (
    .clk_i   (clk_i),
    .we_i    (pwe[SIDE_X_POS]),
    .waddr_i (px_waddr),
    .wdata_i (wcell),
    .re_i    (re),
    .raddr_i (px_raddr),
    .rdata_o (rplane[SIDE_X_POS])
  );

  vfv_ram #(.DEPTH(PZ_DEPTH), .WIDTH(CELL_W)) u_pz_neg (
    .clk_i   (clk_i),
    .we_i    (pwe[SIDE_Z_NEG]),
    .waddr_i (pz_waddr),
    .wdata_i (wcell),
    .re_i    (re),
    .raddr_i (pz_raddr),
    .rdata_o (rplane[SIDE_Z_NEG])
  );

  vfv_ram #(.DEPTH(PZ_DEPTH), .WIDTH(CELL_W)) u_pz_pos (
    .clk_i   (clk_i),
    .we_i    (pwe[SIDE_Z_POS]),
    .waddr_i (pz_waddr),
    .wdata_i (wcell),
    .re_i    (re),
    .raddr_i (pz_raddr),
    .rdata_o (rplane[SIDE_Z_POS])
  );

  always_comb begin
    for (int i = 0; i < NUM_RD; i++) begin
      rd_o.cells[i] = rcell[i];
    end
    rd_o.px_neg = rplane[SIDE_X_NEG];
    rd_o.px_pos = rplane[SIDE_X_POS];
    rd_o.pz_neg = rplane[SIDE_Z_NEG];
    rd_o.pz_pos = rplane[SIDE_Z_POS];
  end

  assign busy_o = clr_busy_q;
  assign info_o = info_q;

endmodule

[src/vfv_cull.sv]
// Face mask logic: combines the read cells, plane cells and neighbor flags.
module vfv_cull import vfv_pkg::*; (
  input  info_t          info_i,
  input  rd_data_t       rd_i,
  input  logic [NB_W-1:0] nb_i,
  output res_t           res_o
);

  logic              w;
  logic [MASK_W-1:0] m;

  always_comb begin
    w = info_i.water;
    m = '0;
    m[FACE_ZP] = info_i.z_hi ? (!nb_i[NB_ZP] || open_face(rd_i.pz_pos, w))
                             : open_face(rd_i.cells[RD_ZP], w);
    m[FACE_XP] = info_i.x_hi ? (!nb_i[NB_XP] || open_face(rd_i.px_pos, w))
                             : open_face(rd_i.cells[RD_XP], w);
    m[FACE_ZN] = info_i.z_lo ? (!nb_i[NB_ZN] || open_face(rd_i.pz_neg, w))
                             : open_face(rd_i.cells[RD_ZN], w);
    m[FACE_XN] = info_i.x_lo ? (!nb_i[NB_XN] || open_face(rd_i.px_neg, w))
                             : open_face(rd_i.cells[RD_XN], w);
    m[FACE_YP] = info_i.y_hi || open_face(rd_i.cells[RD_YP], w);
    m[FACE_YN] = info_i.y_lo || open_face(rd_i.cells[RD_YN], w);
    if (info_i.in_range) begin
      res_o.face_mask        = m;
      res_o.self_occupied    = rd_i.cells[RD_SELF].occupied;
      res_o.self_transparent = rd_i.cells[RD_SELF].transparent;
    end else begin
      res_o = '0;
    end
  end

endmodule

[src/voxel_face_visibility.sv]
// Top level of the voxel face visibility block.
// Use: the input channel carries write and query transactions for one 16x16x16 chunk.
// A local write stores a cell, a plane write stores a cell of a neighbor chunk's
// boundary plane, and a query returns the cell's visible-face mask and its own bits
// on the output channel. Writes and unused kinds produce no output transaction.
// The configuration port sets which of the four x and z neighbor chunks exist; the
// user must write it only while no transaction is in flight; no logic enforces it.
// Path: a query accepted into the input register moves on through the memory read
// register to the result register (three registers: input, memory read, result).
// Throughput: one transaction per cycle outside the sweep and output stalls, set by
// the seven copies of the local cell memory, each serving one of a query's cell reads.
// Reset: the neighbor register clears to zero and a sweep writes every local and
// plane cell empty, one entry per cycle; in_stall_o stays high until the sweep is
// done. Configuration writes are taken during the sweep.
// Output stall: a stalled result holds on the output register; the input, memory
// and result stages each move on whenever the stage after them has room.
module voxel_face_visibility import vfv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_kind_i,
  input  logic [COORD_W-1:0] in_pos_x_i,
  input  logic [COORD_W-1:0] in_pos_y_i,
  input  logic [COORD_W-1:0] in_pos_z_i,
  input  logic [1:0]         in_plane_side_i,
  input  logic               in_cell_occupied_i,
  input  logic               in_cell_transparent_i,
  input  logic               in_water_rule_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MASK_W-1:0]  out_face_mask_o,
  output logic               out_self_occupied_o,
  output logic               out_self_transparent_o,
  input  logic               cfg_we_i,
  input  logic [NB_W-1:0]    cfg_wdata_i
);

  logic            s0_v_q, s0_v_d;
  logic            s1_v_q, s1_v_d;
  logic            out_v_q, out_v_d;
  logic [NB_W-1:0] np_q, np_d;
  item_t           s0_q;
  res_t            out_res_q;

  logic            busy;
  logic            out_ready, s1_ready, s0_ready;
  logic            accept, fire0, s1_fire;
  info_t           info;
  rd_data_t        rd;
  res_t            res;

  assign out_ready = !out_v_q || !out_stall_i;
  assign s1_ready  = !s1_v_q || out_ready;
  assign s0_ready  = !s0_v_q || s1_ready;
  assign fire0     = s0_v_q && s1_ready;
  assign s1_fire   = s1_v_q && out_ready;
  assign in_stall_o = busy || !s0_ready;
  assign accept    = in_valid_i && !in_stall_o;

  always_comb begin
    s0_v_d = s0_v_q;
    s1_v_d = s1_v_q;
    out_v_d = out_v_q;
    np_d = cfg_we_i ? cfg_wdata_i : np_q;
    if (accept) begin
      s0_v_d = 1'b1;
    end else if (fire0) begin
      s0_v_d = 1'b0;
    end
    if (fire0) begin
      s1_v_d = s0_q.kind == KIND_QUERY;
    end else if (s1_fire) begin
      s1_v_d = 1'b0;
    end
    if (s1_fire) begin
      out_v_d = 1'b1;
    end else if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      np_q    <= '0;
    end else begin
      s0_v_q  <= s0_v_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      np_q    <= np_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_q.kind        <= in_kind_i;
      s0_q.x           <= in_pos_x_i;
      s0_q.y           <= in_pos_y_i;
      s0_q.z           <= in_pos_z_i;
      s0_q.side        <= in_plane_side_i;
      s0_q.bits        <= '{transparent: in_cell_transparent_i,
                            occupied: in_cell_occupied_i};
      s0_q.water       <= in_water_rule_i;
    end
    if (s1_fire) begin
      out_res_q <= res;
    end
  end

  vfv_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire0),
    .item_i (s0_q),
    .busy_o (busy),
    .info_o (info),
    .rd_o   (rd)
  );

  vfv_cull u_cull (
    .info_i (info),
    .rd_i   (rd),
    .nb_i   (np_q),
    .res_o  (res)
  );

  assign out_valid_o            = out_v_q;
  assign out_face_mask_o        = out_res_q.face_mask;
  assign out_self_occupied_o    = out_res_q.self_occupied;
  assign out_self_transparent_o = out_res_q.self_transparent;

endmodule

[src/vfv_checker.sv]
// Port-level checker of the voxel face visibility block and its bind statement.
`include "voxel_face_visibility_defines.svh"

module vfv_checker import vfv_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [MASK_W-1:0] out_face_mask_o,
  input logic              out_self_occupied_o,
  input logic              out_self_transparent_o
);

  // No result may be presented while reset is asserted.
  `VFV_ASSERT_RST(a_reset_no_result, !rst_ni |-> !out_valid_o, "result valid during reset")

  // Leaving reset starts the clearing sweep, so the input is stalled right after it.
  `VFV_ASSERT_RST(a_sweep_after_reset, $past(!rst_ni) |-> in_stall_o, "input open before clear")

  // A stalled result transaction stays on the port unchanged.
  `VFV_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_face_mask_o) && $stable(out_self_occupied_o) && $stable(out_self_transparent_o), "stalled result changed")

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (.*);
